// ===== sv/pwm_pkg.sv =====
`timescale 1ns / 1ps

package pwm_pkg;

	localparam int COORD_BITS      = 11;
	localparam int FRAC_BITS       = 8;
	localparam int OUT_BITS        = 21;
	localparam int NTERMS          = 15;
	localparam int COEF_BITS       = 32;
	localparam int COEF_BASE_SHIFT = 8;
	localparam int COEF_DEG_SHIFT  = 11;
	localparam int MAX_DEG         = 4;
	localparam int PADDR_BITS      = 3;

	// widest rounded term over all degrees
	localparam int TERM_BITS = COEF_BITS + FRAC_BITS - COEF_BASE_SHIFT
		+ ((COORD_BITS > COEF_DEG_SHIFT) ? MAX_DEG * (COORD_BITS - COEF_DEG_SHIFT) : 0);
	localparam int ACC_BITS  = TERM_BITS + 5;
	localparam int PROD_BITS = COEF_BITS + MAX_DEG * COORD_BITS;

	typedef logic signed [COEF_BITS-1:0] coef_t;
	typedef logic [2:0] pow_t;

	typedef struct packed {
		logic       coefficient_set;
		logic [3:0] term_count;
	} cfg_t;

	// [set][axis][term]
	localparam coef_t COEF [2][2][NTERMS] = '{
		'{
			'{12629, 164130, -140946, 749360, 2832579, 432070,
			  2684736, -3917228, -7356653, 1368324,
			  -7480960, 3194210, -4755807, 3623312, -2277817},
			'{10232, -150407, 323823, 1383303, 509616, 1519836,
			  -4739895, 1937464, -59992, -6267238,
			  1358187, -7545965, 1268675, -136413, 6742339}
		},
		'{
			'{13274, 226417, -123044, 781404, 1902302, 517075,
			  385382, -5110247, -3390216, 2423596,
			  -520667, -1333086, 3599844, -1175596, -8800107},
			'{3235, -116968, 432722, 1318369, 338182, 464792,
			  -3796805, 837607, 89436, 1450512,
			  -1177600, -194732, -3206111, -13842, -16748590}
		}
	};

	localparam pow_t X_POW [NTERMS] = '{0, 1, 0, 1, 2, 0, 2, 1, 3, 0, 3, 2, 1, 4, 0};
	localparam pow_t Y_POW [NTERMS] = '{0, 0, 1, 1, 0, 2, 1, 2, 0, 3, 1, 2, 3, 0, 4};

	localparam int RND_BITS = PROD_BITS + FRAC_BITS + 1;

	// |c| * mono * 2^FRAC / 2^(8 + 11 d), round half up
	function automatic logic [TERM_BITS-1:0] round_term(
		input logic [PROD_BITS-1:0] p,
		input pow_t                 deg
	);
		logic [RND_BITS-1:0] w;
		int unsigned         s;
		s = COEF_BASE_SHIFT + COEF_DEG_SHIFT * int'(deg);
		w = RND_BITS'(p) << FRAC_BITS;
		w = w + (RND_BITS'(1) << (s - 1));
		w = w >> s;
		return w[TERM_BITS-1:0];
	endfunction

endpackage

// ===== sv/pwm_ifs.sv =====
`timescale 1ns / 1ps

interface pwm_pixel_if;
	logic                           valid;
	logic                           ready;
	logic [pwm_pkg::COORD_BITS-1:0] pixel_x;
	logic [pwm_pkg::COORD_BITS-1:0] pixel_y;

	modport source(output valid, output pixel_x, output pixel_y, input ready);
	modport sink(input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface pwm_source_if;
	logic                                valid;
	logic                                ready;
	logic signed [pwm_pkg::OUT_BITS-1:0] source_x;
	logic signed [pwm_pkg::OUT_BITS-1:0] source_y;

	modport source(output valid, output source_x, output source_y, input ready);
	modport sink(input valid, input source_x, input source_y, output ready);
endinterface

// ===== sv/pwm_cfg.sv =====
`timescale 1ns / 1ps

module pwm_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pwm_pkg::PADDR_BITS-1:0]   paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output pwm_pkg::cfg_t                    cfg
);

	localparam logic REG_COEF_SET   = 1'b0;
	localparam logic REG_TERM_COUNT = 1'b1;

	logic       coef_set_q;
	logic [3:0] term_count_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_set_q   <= 1'b0;
			term_count_q <= 4'd15;
		end else if (wr_en) begin
			case (paddr[2])
				REG_COEF_SET:   coef_set_q   <= pwdata[0];
				REG_TERM_COUNT: term_count_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_COEF_SET:   prdata = {31'd0, coef_set_q};
			REG_TERM_COUNT: prdata = {28'd0, term_count_q};
			default:        prdata = '0;
		endcase
	end

	assign cfg.coefficient_set = coef_set_q;
	assign cfg.term_count      = term_count_q;

endmodule

// ===== sv/pwm_term.sv =====
`timescale 1ns / 1ps

module pwm_term (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [pwm_pkg::COORD_BITS-1:0]         x,
	input  logic [pwm_pkg::COORD_BITS-1:0]         y,
	input  pwm_pkg::coef_t                         coef,
	input  logic                                   used,
	input  pwm_pkg::pow_t                          x_pow,
	input  pwm_pkg::pow_t                          y_pow,
	output logic signed [pwm_pkg::ACC_BITS-1:0]    term_s6
);

	localparam int CB = pwm_pkg::COORD_BITS;
	localparam int P1 = pwm_pkg::COEF_BITS + CB;
	localparam int P2 = P1 + CB;
	localparam int P3 = P2 + CB;
	localparam int P4 = P3 + CB;

	logic [pwm_pkg::COEF_BITS-1:0] cmag;
	logic                          neg;
	pwm_pkg::pow_t                 deg;

	logic [P1-1:0] p_s2;
	logic [P2-1:0] p_s3;
	logic [P3-1:0] p_s4;
	logic [P4-1:0] p_s5;
	logic [CB-1:0] x_s2, y_s2, x_s3, y_s3, x_s4, y_s4;
	logic          neg_s2, neg_s3, neg_s4, neg_s5;
	logic [pwm_pkg::TERM_BITS-1:0] mag;

	// multiplier for power step j: x first, then y, then unity
	function automatic logic [CB-1:0] factor(
		input int unsigned   j,
		input pwm_pkg::pow_t xp,
		input pwm_pkg::pow_t dg,
		input logic [CB-1:0] xv,
		input logic [CB-1:0] yv
	);
		if (j < int'(xp))
			return xv;
		else if (j < int'(dg))
			return yv;
		else
			return CB'(1);
	endfunction

	assign deg  = x_pow + y_pow;
	assign neg  = coef[pwm_pkg::COEF_BITS-1];
	assign cmag = !used ? '0 : (neg ? 32'(-coef) : 32'(coef));
	assign mag  = pwm_pkg::round_term(pwm_pkg::PROD_BITS'(p_s5), deg);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2   <= P1'(cmag) * P1'(factor(0, x_pow, deg, x, y));
			x_s2   <= x;
			y_s2   <= y;
			neg_s2 <= neg;

			p_s3   <= P2'(p_s2) * P2'(factor(1, x_pow, deg, x_s2, y_s2));
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			neg_s3 <= neg_s2;

			p_s4   <= P3'(p_s3) * P3'(factor(2, x_pow, deg, x_s3, y_s3));
			x_s4   <= x_s3;
			y_s4   <= y_s3;
			neg_s4 <= neg_s3;

			p_s5   <= P4'(p_s4) * P4'(factor(3, x_pow, deg, x_s4, y_s4));
			neg_s5 <= neg_s4;

			term_s6 <= neg_s5 ? -$signed(pwm_pkg::ACC_BITS'(mag))
			                  : $signed(pwm_pkg::ACC_BITS'(mag));
		end
	end

endmodule

// ===== sv/pwm_sum.sv =====
`timescale 1ns / 1ps

module pwm_sum (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [pwm_pkg::ACC_BITS-1:0]    terms [pwm_pkg::NTERMS],
	output logic signed [pwm_pkg::OUT_BITS-1:0]    sat
);

	localparam int AW      = pwm_pkg::ACC_BITS;
	localparam int OW      = pwm_pkg::OUT_BITS;
	localparam int GROUP   = 4;
	localparam int NGROUPS = (pwm_pkg::NTERMS + GROUP - 1) / GROUP;

	localparam logic signed [AW-1:0] LO_LIM = -(AW'(1) <<< (OW - 1));
	localparam logic signed [AW-1:0] HI_LIM = (AW'(1) <<< (OW - 1)) - AW'(1);

	logic signed [AW-1:0] gsum [NGROUPS];
	logic signed [AW-1:0] g_s7 [NGROUPS];
	logic signed [AW-1:0] total;
	logic signed [AW-1:0] total_s8;

	always_comb begin
		for (int g = 0; g < NGROUPS; g++) begin
			gsum[g] = '0;
			for (int i = 0; i < GROUP; i++) begin
				if (g * GROUP + i < pwm_pkg::NTERMS)
					gsum[g] = gsum[g] + terms[g * GROUP + i];
			end
		end
	end

	always_comb begin
		total = '0;
		for (int g = 0; g < NGROUPS; g++)
			total = total + g_s7[g];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s7     <= gsum;
			total_s8 <= total;
		end
	end

	always_comb begin
		if (total_s8 < LO_LIM)
			sat = LO_LIM[OW-1:0];
		else if (total_s8 > HI_LIM)
			sat = HI_LIM[OW-1:0];
		else
			sat = total_s8[OW-1:0];
	end

endmodule

// ===== sv/polynomial_warp_map.sv =====
`timescale 1ns / 1ps

// channel  | role                | payload
// ---------+---------------------+-----------------------------------
// pixel    | sink, valid/ready   | pixel_x, pixel_y (unsigned)
// mapped   | source, valid/ready | source_x, source_y (signed, 8 frac)
// apb      | register port       | coefficient_set @0x0, term_count @0x4
//
// One transaction per cycle while mapped is not stalled.
// The path is an input register, four coordinate multiply stages per term, rounding,
// and a two-level adder tree followed by the saturating output register.
// arst_n clears valid bits and registers (set 0, term count 15).
// A stall on mapped freezes the whole pipeline; nothing is dropped or repeated.

module polynomial_warp_map (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pwm_pkg::PADDR_BITS-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	pwm_pixel_if.sink                       pixel,
	pwm_source_if.source                    mapped
);

	localparam int NT = pwm_pkg::NTERMS;
	localparam int CB = pwm_pkg::COORD_BITS;
	localparam int OW = pwm_pkg::OUT_BITS;

	pwm_pkg::cfg_t cfg;
	logic          en;

	logic [CB-1:0]  x_s1, y_s1;
	logic           set_s1;
	pwm_pkg::pow_t  maxdeg_s1;
	pwm_pkg::pow_t  maxdeg;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic out_valid_q;
	logic signed [OW-1:0] src_x_q, src_y_q;

	logic signed [pwm_pkg::ACC_BITS-1:0] term_s6 [2][NT];
	logic signed [OW-1:0]                sat [2];

	pwm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign en          = !out_valid_q || mapped.ready;
	assign pixel.ready = en;

	always_comb begin
		if (cfg.term_count > 4'd10)
			maxdeg = 3'd4;
		else if (cfg.term_count > 4'd6)
			maxdeg = 3'd3;
		else if (cfg.term_count > 4'd3)
			maxdeg = 3'd2;
		else
			maxdeg = 3'd1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1      <= pixel.pixel_x;
			y_s1      <= pixel.pixel_y;
			set_s1    <= cfg.coefficient_set;
			maxdeg_s1 <= maxdeg;
		end
	end

	for (genvar a = 0; a < 2; a++) begin : g_axis
		for (genvar k = 0; k < NT; k++) begin : g_term
			localparam pwm_pkg::pow_t DEG = 3'(pwm_pkg::X_POW[k] + pwm_pkg::Y_POW[k]);

			pwm_term u_term (
				.clk     (clk),
				.en      (en),
				.x       (x_s1),
				.y       (y_s1),
				.coef    (set_s1 ? pwm_pkg::COEF[1][a][k] : pwm_pkg::COEF[0][a][k]),
				.used    (DEG <= maxdeg_s1),
				.x_pow   (pwm_pkg::X_POW[k]),
				.y_pow   (pwm_pkg::Y_POW[k]),
				.term_s6 (term_s6[a][k])
			);
		end

		pwm_sum u_sum (
			.clk   (clk),
			.en    (en),
			.terms (term_s6[a]),
			.sat   (sat[a])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= pixel.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			v_s8        <= v_s7;
			out_valid_q <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			src_x_q <= sat[0];
			src_y_q <= sat[1];
		end
	end

	assign mapped.valid    = out_valid_q;
	assign mapped.source_x = src_x_q;
	assign mapped.source_y = src_y_q;

endmodule
